// ===== hw/rtl/mt19937_64_generator_defines.svh =====
// Assertion macros used by the generator's sequencer.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef MT19937_64_GENERATOR_DEFINES_SVH
`define MT19937_64_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MTG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MTG_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/mtg_pkg.sv =====
package mtg_pkg;

   // State memory geometry.
   localparam int unsigned ADDR_W = 9;
   localparam logic [ADDR_W-1:0] LAST_ADDR = 9'd311;
   localparam logic [ADDR_W-1:0] DEPTH_IDX = 9'd312;
   localparam logic [ADDR_W:0]   STATE_DEPTH_W = 10'd312;
   localparam logic [ADDR_W:0]   MIDDLE_OFFSET = 10'd156;

   // Generator constants.
   localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
   localparam logic [63:0] TEMPER_D     = 64'h5555555555555555;
   localparam logic [63:0] TEMPER_B     = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TEMPER_C     = 64'hFFF7EEE000000000;
   localparam logic [63:0] LOW_MASK     = 64'h000000007FFFFFFF;
   localparam logic [31:0] SEED_MULT_HI = 32'h5851F42D;
   localparam logic [31:0] SEED_MULT_LO = 32'h4C957F2D;
   localparam logic [63:0] RESET_SEED   = 64'd5489;

   // Register index of the seed register.
   localparam logic CSR_IDX_SEED = 1'b0;

   typedef enum logic [3:0] {
      ST_SEED,
      ST_FILL_LL,
      ST_FILL_HL,
      ST_FILL_LH,
      ST_FILL_SUM,
      ST_IDLE,
      ST_TW_PRE,
      ST_TW_LOAD,
      ST_TW_RD,
      ST_TW_WR,
      ST_DRAW_RD,
      ST_DRAW_OUT
   } state_type;

   // Which partial product of the seeding multiply is formed.
   typedef enum logic [1:0] {
      FPH_LL,
      FPH_HL,
      FPH_LH,
      FPH_SUM
   } fill_phase_type;

   typedef struct packed {
      logic           seed_start;
      logic           fill_en;
      fill_phase_type fill_phase;
      logic           tw_pre;
      logic           tw_load;
      logic           tw_read;
      logic           tw_write;
      logic           draw_read;
      logic           out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic k_last;
      logic idx_full;
      logic out_free;
   } dp_status_type;

   // Output tempering.
   function automatic logic [63:0] temper(input logic [63:0] y_in);
      logic [63:0] y;
      y = y_in;
      y = y ^ ((y >> 29) & TEMPER_D);
      y = y ^ ((y << 17) & TEMPER_B);
      y = y ^ ((y << 37) & TEMPER_C);
      y = y ^ (y >> 43);
      return y;
   endfunction

   // Twist of one word: upper bits of the current word, lower bits of the next.
   function automatic logic [63:0] twist_mix(input logic [63:0] cur,
                                             input logic [63:0] nxt);
      logic [63:0] mixed;
      logic [63:0] shifted;
      mixed   = (cur & ~LOW_MASK) | (nxt & LOW_MASK);
      shifted = mixed >> 1;
      if (mixed[0]) begin
         shifted = shifted ^ TWIST_MATRIX;
      end
      return shifted;
   endfunction

endpackage

// ===== hw/rtl/mtg_datapath.sv =====
module mtg_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [63:0]            seed,
   input  mtg_pkg::dp_cmd_type    cmd,
   output mtg_pkg::dp_status_type status,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [63:0]            rsp_tdata
);

   logic [63:0] mem [0:mtg_pkg::STATE_DEPTH_W-1];

   logic [mtg_pkg::ADDR_W-1:0] k_ff, k_in;
   logic [mtg_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [63:0] prev_ff, prev_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff;
   logic [63:0] cur_ff, cur_in;
   logic [63:0] rd_a_ff, rd_b_ff;
   logic [63:0] out_data_ff;
   logic        out_valid_ff, out_valid_in;

   logic [63:0] x_mix;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] fill_word;
   logic [63:0] twist_word;
   logic [mtg_pkg::ADDR_W-1:0] k_wrap;
   logic [mtg_pkg::ADDR_W:0]   k_mid_sum;
   logic [mtg_pkg::ADDR_W-1:0] k_mid;
   logic        wr_en;
   logic [mtg_pkg::ADDR_W-1:0] wr_addr;
   logic [63:0] wr_data;
   logic        rd_en_a;
   logic [mtg_pkg::ADDR_W-1:0] rd_addr_a;
   logic        fill_sum;

   // Seeding recurrence: one 32 x 32 partial product per cycle.
   always_comb begin
      x_mix = prev_ff ^ (prev_ff >> 62);
      mul_a = (cmd.fill_phase == mtg_pkg::FPH_HL) ? x_mix[63:32] : x_mix[31:0];
      mul_b = (cmd.fill_phase == mtg_pkg::FPH_LH) ? mtg_pkg::SEED_MULT_HI
                                                  : mtg_pkg::SEED_MULT_LO;
      mul_p = mul_a * mul_b;
      fill_sum  = cmd.fill_en && (cmd.fill_phase == mtg_pkg::FPH_SUM);
      fill_word = acc_ff + {prod_ff[31:0], 32'b0} + {55'b0, k_ff};
   end

   // Twist neighbour addresses, wrapped around the state.
   always_comb begin
      k_wrap    = (k_ff == mtg_pkg::LAST_ADDR) ? '0 : k_ff + 9'd1;
      k_mid_sum = {1'b0, k_ff} + mtg_pkg::MIDDLE_OFFSET;
      if (k_mid_sum >= mtg_pkg::STATE_DEPTH_W) begin
         k_mid = 9'(k_mid_sum - mtg_pkg::STATE_DEPTH_W);
      end else begin
         k_mid = k_mid_sum[mtg_pkg::ADDR_W-1:0];
      end
      twist_word = rd_b_ff ^ mtg_pkg::twist_mix(cur_ff, rd_a_ff);
   end

   // Memory port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = twist_word;
      if (cmd.seed_start) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = seed;
      end else if (fill_sum) begin
         wr_en   = 1'b1;
         wr_data = fill_word;
      end else if (cmd.tw_write) begin
         wr_en   = 1'b1;
      end
      rd_en_a = cmd.tw_pre || cmd.tw_read || cmd.draw_read;
      if (cmd.tw_pre) begin
         rd_addr_a = '0;
      end else if (cmd.tw_read) begin
         rd_addr_a = k_wrap;
      end else begin
         rd_addr_a = idx_ff;
      end
   end

   // State memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (cmd.tw_read) begin
         rd_b_ff <= mem[k_mid];
      end
   end

   // Next values of the counters and working registers.
   always_comb begin
      k_in = k_ff;
      if (cmd.seed_start) begin
         k_in = 9'd1;
      end else if (cmd.tw_pre) begin
         k_in = '0;
      end else if (fill_sum || cmd.tw_write) begin
         k_in = k_ff + 9'd1;
      end

      idx_in = idx_ff;
      if (cmd.seed_start) begin
         idx_in = mtg_pkg::DEPTH_IDX;
      end else if (cmd.tw_write && status.k_last) begin
         idx_in = '0;
      end else if (cmd.out_load) begin
         idx_in = idx_ff + 9'd1;
      end

      prev_in = prev_ff;
      if (cmd.seed_start) begin
         prev_in = seed;
      end else if (fill_sum) begin
         prev_in = fill_word;
      end

      acc_in = acc_ff;
      if (cmd.fill_en && (cmd.fill_phase == mtg_pkg::FPH_HL)) begin
         acc_in = prod_ff;
      end else if (cmd.fill_en && (cmd.fill_phase == mtg_pkg::FPH_LH)) begin
         acc_in = acc_ff + {prod_ff[31:0], 32'b0};
      end

      cur_in = (cmd.tw_load || cmd.tw_write) ? rd_a_ff : cur_ff;

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         idx_ff       <= mtg_pkg::DEPTH_IDX;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      acc_ff  <= acc_in;
      cur_ff  <= cur_in;
      if (cmd.fill_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.out_load) begin
         out_data_ff <= mtg_pkg::temper(rd_a_ff);
      end
   end

   assign status.k_last   = (k_ff == mtg_pkg::LAST_ADDR);
   assign status.idx_full = (idx_ff >= mtg_pkg::DEPTH_IDX);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== hw/rtl/mtg_ctrl.sv =====
`include "mt19937_64_generator_defines.svh"

module mtg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   draw,
   output logic                   req_tready,
   input  logic                   seed_write,
   input  mtg_pkg::dp_status_type status,
   output mtg_pkg::dp_cmd_type    cmd
);

   mtg_pkg::state_type state_ff, state_in;

   // State register; reset starts the seeding pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtg_pkg::ST_SEED;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.fill_phase = mtg_pkg::FPH_LL;
      req_tready     = 1'b0;
      unique case (state_ff)
         mtg_pkg::ST_SEED: begin
            cmd.seed_start = 1'b1;
            state_in       = mtg_pkg::ST_FILL_LL;
         end
         mtg_pkg::ST_FILL_LL: begin
            cmd.fill_en    = 1'b1;
            cmd.fill_phase = mtg_pkg::FPH_LL;
            state_in       = mtg_pkg::ST_FILL_HL;
         end
         mtg_pkg::ST_FILL_HL: begin
            cmd.fill_en    = 1'b1;
            cmd.fill_phase = mtg_pkg::FPH_HL;
            state_in       = mtg_pkg::ST_FILL_LH;
         end
         mtg_pkg::ST_FILL_LH: begin
            cmd.fill_en    = 1'b1;
            cmd.fill_phase = mtg_pkg::FPH_LH;
            state_in       = mtg_pkg::ST_FILL_SUM;
         end
         mtg_pkg::ST_FILL_SUM: begin
            cmd.fill_en    = 1'b1;
            cmd.fill_phase = mtg_pkg::FPH_SUM;
            state_in       = status.k_last ? mtg_pkg::ST_IDLE : mtg_pkg::ST_FILL_LL;
         end
         mtg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && draw) begin
               state_in = status.idx_full ? mtg_pkg::ST_TW_PRE : mtg_pkg::ST_DRAW_RD;
            end
         end
         mtg_pkg::ST_TW_PRE: begin
            cmd.tw_pre = 1'b1;
            state_in   = mtg_pkg::ST_TW_LOAD;
         end
         mtg_pkg::ST_TW_LOAD: begin
            cmd.tw_load = 1'b1;
            state_in    = mtg_pkg::ST_TW_RD;
         end
         mtg_pkg::ST_TW_RD: begin
            cmd.tw_read = 1'b1;
            state_in    = mtg_pkg::ST_TW_WR;
         end
         mtg_pkg::ST_TW_WR: begin
            cmd.tw_write = 1'b1;
            state_in     = status.k_last ? mtg_pkg::ST_DRAW_RD : mtg_pkg::ST_TW_RD;
         end
         mtg_pkg::ST_DRAW_RD: begin
            cmd.draw_read = 1'b1;
            state_in      = mtg_pkg::ST_DRAW_OUT;
         end
         mtg_pkg::ST_DRAW_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = mtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtg_pkg::ST_SEED;
         end
      endcase
      // A seed write restarts the seeding pass from any state.
      if (seed_write) begin
         state_in = mtg_pkg::ST_SEED;
      end
   end

   // The last twisted word leads straight to reading the requested word.
   `MTG_ASSERT_NEXT(a_twist_to_draw, clock, reset, (state_ff == mtg_pkg::ST_TW_WR) && status.k_last && !seed_write, state_ff == mtg_pkg::ST_DRAW_RD, "twist end did not read the word")
   // A word is only read from a state that has not been used up.
   `MTG_ASSERT_SAME(a_draw_fresh, clock, reset, cmd.draw_read, !status.idx_full, "draw read from spent state")
   // The output register is only loaded when it is free.
   `MTG_ASSERT_SAME(a_out_free, clock, reset, cmd.out_load, status.out_free, "result overwritten before taken")

endmodule

// ===== hw/rtl/mt19937_64_generator.sv =====
// MT19937-64 random word generator. Each request whose draw bit is set returns
// one tempered 64-bit word on the response channel; a request with draw clear is
// taken and produces no response. After reset, and after every write of the seed
// register, the 312-word state is refilled from the seed, each word built from
// three partial products of a shared 32 x 32 multiplier, while no request is
// taken. A draw accepts the request, reads the state memory and tempers the word
// into the output register once it is free; the first draw after seeding, and
// every 312th draw after it, is preceded by a regeneration of the whole state
// that reads two words and writes one for each word. The output register lets
// the next request be taken while a result still waits.
module mt19937_64_generator (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] draw, [7:1] zero
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] random_word
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0]            seed_ff;
   logic                   seed_write;
   mtg_pkg::dp_cmd_type    cmd;
   mtg_pkg::dp_status_type status;

   // Register port decode; the seed register sits at byte address 0.
   assign csr_pready = 1'b1;
   assign seed_write = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[3] == mtg_pkg::CSR_IDX_SEED);
   assign csr_prdata = (csr_paddr[3] == mtg_pkg::CSR_IDX_SEED) ? seed_ff : '0;

   // Seed register.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mtg_pkg::RESET_SEED;
      end else if (seed_write) begin
         seed_ff <= csr_pwdata;
      end
   end

   // Sequencer.
   mtg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .draw       (req_tdata[0]),
      .req_tready (req_tready),
      .seed_write (seed_write),
      .status     (status),
      .cmd        (cmd)
   );

   // State memory, seeding arithmetic, twist and tempering.
   mtg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
